@@ rtl/ubds_pkg.sv @@
// ----------------------------------------------------------------------------
// ubds_pkg
// shared widths, constants and reset values of the baud divisor select unit
// ----------------------------------------------------------------------------
`default_nettype none

package ubds_pkg;

  localparam int CLK_W        = 32;
  localparam int BAUD_W       = 24;
  localparam int TOL_W        = 16;
  localparam int ACT_W        = 32;
  localparam int ERR_W        = 16;
  localparam int DIV_BITS_DEF = 12;

  // width of 2*clock + N*divisor or 2*clock + N*baud
  localparam int NUM_W        = CLK_W + 2;
  // quotient bits of the error and actual baud dividers
  localparam int ERR_QW       = ERR_W + 1;
  localparam int ACT_QW       = 30;

  localparam int CENTI_SCALE  = 10000;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(200);
  localparam logic [ERR_W-1:0] ERR_SAT   = '1;

endpackage

`default_nettype wire

@@ rtl/ubds_if.sv @@
// ----------------------------------------------------------------------------
// ubds_in_if / ubds_out_if
// valid/ready channels for requests and results of the divisor select unit
// ----------------------------------------------------------------------------
`default_nettype none

interface ubds_in_if import ubds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CLK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0] target_baud;

  modport source (output valid, output clock_hz, output target_baud, input ready);
  modport sink   (input valid, input clock_hz, input target_baud, output ready);
endinterface

interface ubds_out_if import ubds_pkg::*; #(
  parameter int DIVISOR_BITS = DIV_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [DIVISOR_BITS-1:0] divisor_value;
  logic                    double_speed;
  logic [ACT_W-1:0]        result_baud;
  logic [ERR_W-1:0]        error_centi_pct;
  logic                    within_tolerance;

  modport source (output valid, output divisor_value, output double_speed,
                  output result_baud, output error_centi_pct,
                  output within_tolerance, input ready);
  modport sink   (input valid, input divisor_value, input double_speed,
                  input result_baud, input error_centi_pct,
                  input within_tolerance, output ready);
endinterface

`default_nettype wire

@@ rtl/ubds_div.sv @@
// ----------------------------------------------------------------------------
// ubds_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
`default_nettype none

module ubds_div #(
  parameter int NW = 34,
  parameter int DW = 30,
  parameter int QW = 13,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               out_v,
  output logic [QW-1:0]      quo,
  output logic [SW-1:0]      out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r   [QW];
  logic [QW-1:0] q_r   [QW];
  logic [SW-1:0] s_r   [QW];
  logic [NW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [CW-1:0] shd;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in   = in_v;
      assign rem_in = num;
      assign d_in   = den;
      assign q_in   = '0;
      assign s_in   = side;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign d_in   = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign s_in   = s_r[i-1];
    end

    assign shd = CW'(d_in) << (QW - 1 - i);
    assign ge  = CW'(rem_in) >= shd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_in | (QW'(ge) << (QW - 1 - i));
        s_r[i] <= s_in;
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? NW'(CW'(rem_in) - shd) : rem_in;
          den_r[i] <= d_in;
        end
      end
    end
  end

  assign out_v    = v_r[QW-1];
  assign quo      = q_r[QW-1];
  assign out_side = s_r[QW-1];

endmodule

`default_nettype wire

@@ rtl/ubds_mode.sv @@
// ----------------------------------------------------------------------------
// ubds_mode
// divisor, resulting baud and error of one oversampling mode, fully pipelined
// ----------------------------------------------------------------------------
`default_nettype none

module ubds_mode import ubds_pkg::*; #(
  parameter int DIVISOR_BITS = DIV_BITS_DEF,
  parameter int NSH          = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_v,
  input  wire logic [CLK_W-1:0]             clock_hz,
  input  wire logic [BAUD_W-1:0]            target_baud,
  input  wire logic [TOL_W-1:0]             tol,
  output logic                              out_v,
  output logic [DIVISOR_BITS-1:0]           value,
  output logic [ACT_W-1:0]                  actual,
  output logic [ERR_W-1:0]                  centi,
  output logic                              ok,
  output logic                              bz,
  output logic [DIVISOR_BITS+27:0]          enm,
  output logic [DIVISOR_BITS:0]             dfull
);

  localparam int DB  = DIVISOR_BITS;
  localparam int EW  = DB + 28;
  localparam int DFW = DB + 1;
  localparam int D1W = BAUD_W + NSH + 1;
  localparam int D2W = DFW + NSH + 1;
  localparam int TW  = EW + 14;
  localparam int PW  = EW + TOL_W;
  localparam int E3W = EW + 16;
  localparam int D3W = EW + 1;
  localparam int OW1 = D1W + DFW;
  localparam int OW3 = D3W + ERR_QW;
  localparam logic [DFW-1:0] DMAX = DFW'(1) << DB;

  typedef struct packed {
    logic [CLK_W-1:0]  c;
    logic [BAUD_W-1:0] b;
    logic              bz;
    logic              ovf;
  } s1_t;

  typedef struct packed {
    logic [CLK_W-1:0]  c;
    logic [BAUD_W-1:0] b;
    logic              bz;
    logic [DFW-1:0]    d;
  } sa_t;

  typedef struct packed {
    logic [CLK_W-1:0] c;
    logic             bz;
    logic [DFW-1:0]   d;
    logic [NUM_W-1:0] num2;
    logic [D2W-1:0]   den2;
    logic [EW-1:0]    den;
  } sb_t;

  typedef struct packed {
    logic             bz;
    logic [DFW-1:0]   d;
    logic [NUM_W-1:0] num2;
    logic [D2W-1:0]   den2;
    logic [EW-1:0]    den;
    logic [EW-1:0]    enm;
  } sc_t;

  typedef struct packed {
    logic             bz;
    logic [DFW-1:0]   d;
    logic [NUM_W-1:0] num2;
    logic [D2W-1:0]   den2;
    logic [EW-1:0]    den;
    logic [EW-1:0]    enm;
    logic [TW-1:0]    tenm;
    logic [PW-1:0]    tolden;
  } sd_t;

  typedef struct packed {
    logic             bz;
    logic             ovf;
    logic             ok;
    logic [DFW-1:0]   d;
    logic [NUM_W-1:0] num2;
    logic [D2W-1:0]   den2;
    logic [EW-1:0]    enm;
  } s3_t;

  typedef struct packed {
    logic             bz;
    logic             ok;
    logic [DFW-1:0]   d;
    logic [EW-1:0]    enm;
    logic [ERR_W-1:0] centi;
  } s2_t;

  // entry stage: numerator, denominator and range check of the ideal divisor
  logic             v0_r;
  logic [NUM_W-1:0] num1_r, num1_nxt;
  logic [D1W-1:0]   den1_r, den1_nxt;
  s1_t              s0_r, s0_nxt;

  always_comb begin
    num1_nxt = NUM_W'({clock_hz, 1'b0}) + (NUM_W'(target_baud) << NSH);
    den1_nxt = D1W'(target_baud) << (NSH + 1);
    s0_nxt.c   = clock_hz;
    s0_nxt.b   = target_baud;
    s0_nxt.bz  = (target_baud == '0);
    s0_nxt.ovf = OW1'(num1_nxt) >= (OW1'(den1_nxt) << DFW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= num1_nxt;
      den1_r <= den1_nxt;
      s0_r   <= s0_nxt;
    end
  end

  logic           v1;
  logic [DFW-1:0] q1;
  s1_t            s1;

  ubds_div #(.NW(NUM_W), .DW(D1W), .QW(DFW), .SW($bits(s1_t))) u_div_ideal (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(v0_r), .num(num1_r), .den(den1_r), .side(s0_r),
    .out_v(v1), .quo(q1), .out_side(s1)
  );

  // clamp the rounded divisor
  logic va_r;
  sa_t  a_r, a_nxt;

  always_comb begin
    a_nxt.c  = s1.c;
    a_nxt.b  = s1.b;
    a_nxt.bz = s1.bz;
    if (s1.ovf || q1 > DMAX) begin
      a_nxt.d = DMAX;
    end else if (q1 == '0) begin
      a_nxt.d = DFW'(1);
    end else begin
      a_nxt.d = q1;
    end
  end

  // divisor times baud, inputs of the actual baud divider
  logic vb_r;
  sb_t  b_r, b_nxt;

  always_comb begin
    b_nxt.c    = a_r.c;
    b_nxt.bz   = a_r.bz;
    b_nxt.d    = a_r.d;
    b_nxt.num2 = NUM_W'({a_r.c, 1'b0}) + (NUM_W'(a_r.d) << NSH);
    b_nxt.den2 = D2W'(a_r.d) << (NSH + 1);
    b_nxt.den  = EW'(EW'(a_r.d) * EW'(a_r.b)) << NSH;
  end

  // absolute error numerator
  logic vc_r;
  sc_t  c_r, c_nxt;

  always_comb begin
    c_nxt.bz   = b_r.bz;
    c_nxt.d    = b_r.d;
    c_nxt.num2 = b_r.num2;
    c_nxt.den2 = b_r.den2;
    c_nxt.den  = b_r.den;
    c_nxt.enm  = (EW'(b_r.c) > b_r.den) ? EW'(b_r.c) - b_r.den : b_r.den - EW'(b_r.c);
  end

  // scaled error and tolerance bound
  logic vd_r;
  sd_t  d_r, d_nxt;

  always_comb begin
    d_nxt.bz     = c_r.bz;
    d_nxt.d      = c_r.d;
    d_nxt.num2   = c_r.num2;
    d_nxt.den2   = c_r.den2;
    d_nxt.den    = c_r.den;
    d_nxt.enm    = c_r.enm;
    d_nxt.tenm   = TW'(c_r.enm) * TW'(CENTI_SCALE);
    d_nxt.tolden = PW'(c_r.den) * PW'(tol);
  end

  // tolerance check and inputs of the error divider
  logic             ve_r;
  s3_t              e_r, e_nxt;
  logic [E3W-1:0]   num3_r, num3_nxt;
  logic [D3W-1:0]   den3_r, den3_nxt;

  always_comb begin
    num3_nxt   = E3W'({d_r.tenm, 1'b0}) + E3W'(d_r.den);
    den3_nxt   = D3W'({d_r.den, 1'b0});
    e_nxt.bz   = d_r.bz;
    e_nxt.ovf  = OW3'(num3_nxt) >= (OW3'(den3_nxt) << ERR_QW);
    e_nxt.ok   = !d_r.bz && (PW'(d_r.tenm) <= d_r.tolden);
    e_nxt.d    = d_r.d;
    e_nxt.num2 = d_r.num2;
    e_nxt.den2 = d_r.den2;
    e_nxt.enm  = d_r.enm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= v1;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      d_r    <= d_nxt;
      e_r    <= e_nxt;
      num3_r <= num3_nxt;
      den3_r <= den3_nxt;
    end
  end

  logic              v3;
  logic [ERR_QW-1:0] q3;
  s3_t               s3;

  ubds_div #(.NW(E3W), .DW(D3W), .QW(ERR_QW), .SW($bits(s3_t))) u_div_err (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(ve_r), .num(num3_r), .den(den3_r), .side(e_r),
    .out_v(v3), .quo(q3), .out_side(s3)
  );

  s2_t s2_in;

  always_comb begin
    s2_in.bz  = s3.bz;
    s2_in.ok  = s3.ok;
    s2_in.d   = s3.d;
    s2_in.enm = s3.enm;
    if (s3.bz || s3.ovf || q3[ERR_QW-1]) begin
      s2_in.centi = ERR_SAT;
    end else begin
      s2_in.centi = q3[ERR_W-1:0];
    end
  end

  logic              v2;
  logic [ACT_QW-1:0] q2;
  s2_t               s2;

  ubds_div #(.NW(NUM_W), .DW(D2W), .QW(ACT_QW), .SW($bits(s2_t))) u_div_act (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(v3), .num(s3.num2), .den(s3.den2), .side(s2_in),
    .out_v(v2), .quo(q2), .out_side(s2)
  );

  assign out_v  = v2;
  assign value  = DB'(s2.d - DFW'(1));
  assign actual = ACT_W'(q2);
  assign centi  = s2.centi;
  assign ok     = s2.ok;
  assign bz     = s2.bz;
  assign enm    = s2.enm;
  assign dfull  = s2.d;

endmodule

`default_nettype wire

@@ rtl/uart_baud_divisor_select_unit.sv @@
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_unit
// picks oversampling 16 or 8 and the divisor value for a clock and baud rate
// ----------------------------------------------------------------------------
// throughput: one request per cycle; the bit-per-stage divider pipelines set
//   the depth and a stalled output holds the whole pipeline
// reset: synchronous, clears all valid bits and loads tolerance with 200
// ----------------------------------------------------------------------------
`default_nettype none

module uart_baud_divisor_select_unit import ubds_pkg::*; #(
  parameter int DIVISOR_BITS = DIV_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [TOL_W-1:0] cfg_wdata,
  ubds_in_if.sink               in_ch,
  ubds_out_if.source            out_ch
);

  localparam int DB  = DIVISOR_BITS;
  localparam int EW  = DB + 28;
  localparam int DFW = DB + 1;
  localparam int XW  = EW + DFW + 1;

  typedef struct packed {
    logic [DB-1:0]    value16;
    logic [DB-1:0]    value8;
    logic [ACT_W-1:0] actual16;
    logic [ACT_W-1:0] actual8;
    logic [ERR_W-1:0] centi16;
    logic [ERR_W-1:0] centi8;
    logic             ok16;
    logic             ok8;
    logic             bz;
    logic [XW-1:0]    lhs;
    logic [XW-1:0]    rhs;
  } cmp_t;

  typedef struct packed {
    logic [DB-1:0]    divisor_value;
    logic             double_speed;
    logic [ACT_W-1:0] result_baud;
    logic [ERR_W-1:0] error_centi_pct;
    logic             within_tolerance;
  } res_t;

  logic [TOL_W-1:0] tol_r;
  logic             en;
  logic             out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  logic           v16, v8, ok16, ok8, bz16, bz8;
  logic [DB-1:0]  value16, value8;
  logic [ACT_W-1:0] actual16, actual8;
  logic [ERR_W-1:0] centi16, centi8;
  logic [EW-1:0]  enm16, enm8;
  logic [DFW-1:0] d16, d8;

  ubds_mode #(.DIVISOR_BITS(DB), .NSH(4)) u_mode16 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_ch.valid),
    .clock_hz(in_ch.clock_hz), .target_baud(in_ch.target_baud), .tol(tol_r),
    .out_v(v16), .value(value16), .actual(actual16), .centi(centi16),
    .ok(ok16), .bz(bz16), .enm(enm16), .dfull(d16)
  );

  ubds_mode #(.DIVISOR_BITS(DB), .NSH(3)) u_mode8 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_ch.valid),
    .clock_hz(in_ch.clock_hz), .target_baud(in_ch.target_baud), .tol(tol_r),
    .out_v(v8), .value(value8), .actual(actual8), .centi(centi8),
    .ok(ok8), .bz(bz8), .enm(enm8), .dfull(d8)
  );

  // cross products: err8 < err16 when 2*enm8*d16 < enm16*d8
  logic vx_r;
  cmp_t x_r, x_nxt;

  always_comb begin
    x_nxt.value16  = value16;
    x_nxt.value8   = value8;
    x_nxt.actual16 = actual16;
    x_nxt.actual8  = actual8;
    x_nxt.centi16  = centi16;
    x_nxt.centi8   = centi8;
    x_nxt.ok16     = ok16;
    x_nxt.ok8      = ok8;
    x_nxt.bz       = bz16 | bz8;
    x_nxt.lhs      = (XW'(enm8) * XW'(d16)) << 1;
    x_nxt.rhs      = XW'(enm16) * XW'(d8);
  end

  // mode selection
  res_t out_r, out_nxt;
  logic dbl;

  always_comb begin
    if (x_r.ok16 && !x_r.ok8) begin
      dbl = 1'b0;
    end else if (!x_r.ok16 && x_r.ok8) begin
      dbl = 1'b1;
    end else begin
      dbl = !x_r.bz && (x_r.lhs < x_r.rhs);
    end
    out_nxt.double_speed     = dbl;
    out_nxt.divisor_value    = dbl ? x_r.value8  : x_r.value16;
    out_nxt.result_baud      = dbl ? x_r.actual8 : x_r.actual16;
    out_nxt.error_centi_pct  = dbl ? x_r.centi8  : x_r.centi16;
    out_nxt.within_tolerance = dbl ? x_r.ok8     : x_r.ok16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vx_r    <= v16 & v8;
      out_v_r <= vx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.divisor_value    = out_r.divisor_value;
  assign out_ch.double_speed     = out_r.double_speed;
  assign out_ch.result_baud      = out_r.result_baud;
  assign out_ch.error_centi_pct  = out_r.error_centi_pct;
  assign out_ch.within_tolerance = out_r.within_tolerance;

endmodule

`default_nettype wire

@@ rtl/ubds_checker.sv @@
// ----------------------------------------------------------------------------
// ubds_checker
// port-level checks of the baud divisor select unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ubds_checker import ubds_pkg::*; #(
  parameter int DIVISOR_BITS = DIV_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [DIVISOR_BITS-1:0] divisor_value,
  input wire logic [ACT_W-1:0]        result_baud,
  input wire logic [ERR_W-1:0]        error_centi_pct
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(divisor_value) && $stable(result_baud)
      && $stable(error_centi_pct))
    else $error("result payload changed while stalled");

  // the request side moves exactly when the pipeline advances
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow pipeline advance");

  // reset leaves no result beat
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind uart_baud_divisor_select_unit ubds_checker #(.DIVISOR_BITS(DIVISOR_BITS)) u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .divisor_value(out_ch.divisor_value),
  .result_baud(out_ch.result_baud),
  .error_centi_pct(out_ch.error_centi_pct)
);

`default_nettype wire
